FILE: rtl/core/cgm_pkg.sv
// shared types, constants and helper functions of the color gradient map
package cgm_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;
  localparam int ROWS_KEPT  = 8;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int WIDTH_W    = COL_W + 1;
  localparam int ROW_W      = $clog2(MAX_HEIGHT) + 1;
  localparam int ROWSEL_W   = $clog2(ROWS_KEPT);
  localparam int ADDR_W     = ROWSEL_W + COL_W;
  localparam int PIX_W      = 24;
  localparam int ACC_W      = 29;
  localparam int CFG_W      = 18;
  localparam int MAG_W      = 18;
  localparam int ORIENT_W   = 16;
  localparam int CORD_W     = 50;
  localparam int Z_W        = 21;

  localparam logic [15:0] Y_COEF_R  = 16'd13933;
  localparam logic [15:0] Y_COEF_G  = 16'd46871;
  localparam logic [15:0] Y_COEF_B  = 16'd4732;
  localparam logic signed [17:0] CB_COEF = 18'sd35318;
  localparam logic signed [17:0] CR_COEF = 18'sd41615;
  localparam logic [15:0] SMOOTH_MAX = 16'd65280;
  localparam logic signed [Z_W-1:0] PI_Q16 = 21'sd205887;
  localparam logic signed [Z_W-1:0] PI_Q13 = 21'sd25736;
  localparam logic [MAG_W-1:0] MAG_MAX = 18'd262143;

  typedef enum logic [2:0] {
    CFG_IMAGE_WIDTH  = 3'd0,
    CFG_WEIGHT_D0    = 3'd1,
    CFG_WEIGHT_D1    = 3'd2,
    CFG_WEIGHT_D2    = 3'd3,
    CFG_WEIGHT_D4    = 3'd4,
    CFG_WEIGHT_D5    = 3'd5,
    CFG_WEIGHT_D8    = 3'd6,
    CFG_MAG_THRESH   = 3'd7
  } cfg_index_t;

  typedef struct packed {
    logic       command;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } in_item_t;

  typedef struct packed {
    logic [MAG_W-1:0]           magnitude;
    logic signed [ORIENT_W-1:0] orientation;
    logic                       orientation_undefined;
    logic [MAG_W-1:0]           frame_max;
    logic                       last;
  } out_item_t;

  typedef struct packed {
    logic [15:0] w0;
    logic [15:0] w1;
    logic [15:0] w2;
    logic [15:0] w4;
    logic [15:0] w5;
    logic [15:0] w8;
  } weights_t;

  typedef struct packed {
    logic [ROW_W-1:0]   oi;
    logic [COL_W-1:0]   oj;
    logic [ROW_W-1:0]   bottom;
    logic [WIDTH_W-1:0] width;
  } job_t;

  typedef struct packed {
    logic [15:0]        y;
    logic signed [16:0] cb;
    logic signed [16:0] cr;
  } ycc_t;

  typedef struct packed {
    logic [MAG_W-1:0]           magnitude;
    logic signed [ORIENT_W-1:0] orientation;
    logic                       undef;
  } grad_res_t;

  function automatic logic [WIDTH_W-1:0] clamp_width(input logic [WIDTH_W-1:0] w);
    logic [WIDTH_W-1:0] r;
    if (w == '0) r = WIDTH_W'(1);
    else if (w > WIDTH_W'(MAX_WIDTH)) r = WIDTH_W'(MAX_WIDTH);
    else r = w;
    return r;
  endfunction

  function automatic logic [15:0] tap_weight(input logic [1:0] ady, input logic [1:0] adx,
                                             input weights_t w);
    logic [15:0] r;
    priority if (ady == 2'd0 && adx == 2'd0) r = w.w0;
    else if ({1'b0, ady} + {1'b0, adx} == 3'd1) r = w.w1;
    else if (ady == 2'd1 && adx == 2'd1) r = w.w2;
    else if ({1'b0, ady} + {1'b0, adx} == 3'd2) r = w.w4;
    else if ({1'b0, ady} + {1'b0, adx} == 3'd3) r = w.w5;
    else r = w.w8;
    return r;
  endfunction

  function automatic logic signed [Z_W-1:0] atan_q16(input logic [3:0] i);
    logic signed [Z_W-1:0] r;
    unique case (i)
      4'd0:    r = 21'sd51472;
      4'd1:    r = 21'sd30386;
      4'd2:    r = 21'sd16055;
      4'd3:    r = 21'sd8150;
      4'd4:    r = 21'sd4091;
      4'd5:    r = 21'sd2047;
      4'd6:    r = 21'sd1024;
      4'd7:    r = 21'sd512;
      4'd8:    r = 21'sd256;
      4'd9:    r = 21'sd128;
      4'd10:   r = 21'sd64;
      4'd11:   r = 21'sd32;
      4'd12:   r = 21'sd16;
      4'd13:   r = 21'sd8;
      4'd14:   r = 21'sd4;
      default: r = 21'sd2;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/core/cgm_line_store.sv
// rgb line store: last rows of the frame, one write and one registered read port
module cgm_line_store import cgm_pkg::*; (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [PIX_W-1:0]  wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [PIX_W-1:0]  rd_data
);

  logic [PIX_W-1:0] mem [ROWS_KEPT*MAX_WIDTH];
  logic [PIX_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

FILE: rtl/core/cgm_smooth.sv
// 5x5 gaussian tap sequencer and luma/chroma conversion for the four corners
module cgm_smooth import cgm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  job_t              job,
  input  weights_t          weights,
  input  logic [PIX_W-1:0]  rd_data,
  output logic [ADDR_W-1:0] rd_addr,
  output logic              done,
  output ycc_t [3:0]        corners
);

  typedef enum logic [7:0] {
    SM_IDLE = 8'b0000_0001,
    SM_TAP  = 8'b0000_0010,
    SM_MAC  = 8'b0000_0100,
    SM_RND  = 8'b0000_1000,
    SM_YP   = 8'b0001_0000,
    SM_YS   = 8'b0010_0000,
    SM_CP   = 8'b0100_0000,
    SM_CS   = 8'b1000_0000
  } sm_state_t;

  sm_state_t state_r, state_nxt;
  job_t job_r, job_nxt;
  logic [1:0] corner_r, corner_nxt;
  logic [2:0] dy_r, dy_nxt, dx_r, dx_nxt;
  logic vld_r, vld_nxt;
  logic [15:0] wt_r, wt_nxt;
  logic [ACC_W-1:0] acc_r [3];
  logic [ACC_W-1:0] acc_nxt [3];
  logic [15:0] s_r [3];
  logic [15:0] s_nxt [3];
  logic [31:0] py_r [3];
  logic [31:0] py_nxt [3];
  logic [15:0] y_r, y_nxt;
  logic signed [34:0] pb_r, pb_nxt, pr_r, pr_nxt;
  ycc_t [3:0] corners_r, corners_nxt;

  logic [ROW_W-1:0] ci, ib, trow;
  logic [COL_W-1:0] cj, jr, tcol;
  logic [WIDTH_W-1:0] oj_inc;
  logic signed [ROW_W+1:0] rs;
  logic signed [WIDTH_W:0] cs;
  logic [1:0] ady, adx;
  logic [ACC_W-1:0] rnd_sum;
  logic [20:0] rnd;
  logic [33:0] ysum;
  logic signed [16:0] db, dr;
  logic signed [34:0] cb_t, cr_t;
  logic [7:0] chan [3];

  always_comb begin
    oj_inc = {1'b0, job_r.oj} + WIDTH_W'(1);
    jr = (oj_inc < job_r.width) ? oj_inc[COL_W-1:0] : COL_W'(job_r.width - WIDTH_W'(1));
    ib = (job_r.oi < job_r.bottom) ? job_r.oi + ROW_W'(1) : job_r.bottom;
    ci = corner_r[1] ? ib : job_r.oi;
    cj = corner_r[0] ? jr : job_r.oj;
    rs = $signed({2'b00, ci}) + $signed({{(ROW_W-1){1'b0}}, dy_r}) - (ROW_W+2)'(2);
    cs = $signed({2'b00, cj}) + $signed({{(WIDTH_W-2){1'b0}}, dx_r}) - (WIDTH_W+1)'(2);
    if (rs < 0) trow = '0;
    else if (rs > $signed({2'b00, job_r.bottom})) trow = job_r.bottom;
    else trow = rs[ROW_W-1:0];
    if (cs < 0) tcol = '0;
    else if (cs >= $signed({1'b0, job_r.width})) tcol = COL_W'(job_r.width - WIDTH_W'(1));
    else tcol = cs[COL_W-1:0];
    rd_addr = {trow[ROWSEL_W-1:0], tcol};
    ady = (dy_r >= 3'd2) ? 2'(dy_r - 3'd2) : 2'(3'd2 - dy_r);
    adx = (dx_r >= 3'd2) ? 2'(dx_r - 3'd2) : 2'(3'd2 - dx_r);
  end

  always_comb begin
    state_nxt   = state_r;
    job_nxt     = job_r;
    corner_nxt  = corner_r;
    dy_nxt      = dy_r;
    dx_nxt      = dx_r;
    vld_nxt     = 1'b0;
    wt_nxt      = wt_r;
    s_nxt       = s_r;
    py_nxt      = py_r;
    y_nxt       = y_r;
    pb_nxt      = pb_r;
    pr_nxt      = pr_r;
    corners_nxt = corners_r;
    done        = 1'b0;
    chan[0] = rd_data[23:16];
    chan[1] = rd_data[15:8];
    chan[2] = rd_data[7:0];
    rnd_sum = '0;
    rnd     = '0;
    for (int c = 0; c < 3; c++) begin
      acc_nxt[c] = vld_r ? acc_r[c] + ACC_W'(wt_r * chan[c]) : acc_r[c];
    end
    ysum = 34'(py_r[0]) + 34'(py_r[1]) + 34'(py_r[2]) + 34'd32768;
    db = $signed({1'b0, s_r[2]}) - $signed({1'b0, y_r});
    dr = $signed({1'b0, s_r[0]}) - $signed({1'b0, y_r});
    cb_t = pb_r + 35'sd32768;
    cr_t = pr_r + 35'sd32768;
    unique case (state_r)
      SM_IDLE: begin
        if (start) begin
          job_nxt    = job;
          corner_nxt = '0;
          dy_nxt     = '0;
          dx_nxt     = '0;
          for (int c = 0; c < 3; c++) acc_nxt[c] = '0;
          state_nxt  = SM_TAP;
        end
      end
      SM_TAP: begin
        vld_nxt = 1'b1;
        wt_nxt  = tap_weight(ady, adx, weights);
        if (dx_r == 3'd4) begin
          dx_nxt = '0;
          if (dy_r == 3'd4) state_nxt = SM_MAC;
          else dy_nxt = dy_r + 3'd1;
        end else begin
          dx_nxt = dx_r + 3'd1;
        end
      end
      SM_MAC: state_nxt = SM_RND;
      SM_RND: begin
        for (int c = 0; c < 3; c++) begin
          rnd_sum = acc_r[c] + ACC_W'(128);
          rnd = rnd_sum[ACC_W-1:8];
          s_nxt[c] = (rnd > 21'(SMOOTH_MAX)) ? SMOOTH_MAX : rnd[15:0];
        end
        state_nxt = SM_YP;
      end
      SM_YP: begin
        py_nxt[0] = Y_COEF_R * s_r[0];
        py_nxt[1] = Y_COEF_G * s_r[1];
        py_nxt[2] = Y_COEF_B * s_r[2];
        state_nxt = SM_YS;
      end
      SM_YS: begin
        y_nxt = ysum[31:16];
        state_nxt = SM_CP;
      end
      SM_CP: begin
        pb_nxt = db * CB_COEF;
        pr_nxt = dr * CR_COEF;
        state_nxt = SM_CS;
      end
      SM_CS: begin
        corners_nxt[corner_r].y  = y_r;
        corners_nxt[corner_r].cb = cb_t[32:16];
        corners_nxt[corner_r].cr = cr_t[32:16];
        dy_nxt = '0;
        dx_nxt = '0;
        if (corner_r == 2'd3) begin
          done = 1'b1;
          state_nxt = SM_IDLE;
        end else begin
          corner_nxt = corner_r + 2'd1;
          for (int c = 0; c < 3; c++) acc_nxt[c] = '0;
          state_nxt = SM_TAP;
        end
      end
      default: state_nxt = SM_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SM_IDLE;
      vld_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      vld_r   <= vld_nxt;
    end
    job_r     <= job_nxt;
    corner_r  <= corner_nxt;
    dy_r      <= dy_nxt;
    dx_r      <= dx_nxt;
    wt_r      <= wt_nxt;
    acc_r     <= acc_nxt;
    s_r       <= s_nxt;
    py_r      <= py_nxt;
    y_r       <= y_nxt;
    pb_r      <= pb_nxt;
    pr_r      <= pr_nxt;
    corners_r <= corners_nxt;
  end

  assign corners = corners_r;

endmodule

FILE: rtl/core/cgm_grad.sv
// 2x2 gradient, iterative square root and iterative cordic orientation
module cgm_grad import cgm_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  ycc_t [3:0]       corners,
  input  logic [MAG_W-1:0] threshold,
  output logic             done,
  output grad_res_t        result
);

  typedef enum logic [6:0] {
    G_IDLE = 7'b000_0001,
    G_DIFF = 7'b000_0010,
    G_SQ   = 7'b000_0100,
    G_SQRT = 7'b000_1000,
    G_MAG  = 7'b001_0000,
    G_CORD = 7'b010_0000,
    G_FIN  = 7'b100_0000
  } g_state_t;

  g_state_t state_r, state_nxt;
  logic signed [19:0] g_r [6];
  logic signed [19:0] g_nxt [6];
  logic signed [21:0] sx_r, sx_nxt, sy_r, sy_nxt;
  logic [2:0] idx_r, idx_nxt;
  logic [37:0] sumsq_r, sumsq_nxt;
  logic [37:0] rem_r, rem_nxt, bit_r, bit_nxt;
  logic [38:0] root_r, root_nxt;
  logic signed [CORD_W-1:0] x_r, x_nxt, y_r, y_nxt;
  logic signed [Z_W-1:0] z_r, z_nxt;
  logic [3:0] it_r, it_nxt;
  grad_res_t res_r, res_nxt;

  logic signed [17:0] cv [4][3];
  logic signed [39:0] sq;
  logic [38:0] trial;
  logic [19:0] mag_full;
  logic [MAG_W-1:0] mag;
  logic signed [CORD_W-1:0] xs, ys, shx, shy;
  logic signed [Z_W-1:0] zr;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      cv[k][0] = $signed({2'b00, corners[k].y});
      cv[k][1] = 18'(corners[k].cb);
      cv[k][2] = 18'(corners[k].cr);
    end
  end

  always_comb begin
    state_nxt = state_r;
    g_nxt     = g_r;
    sx_nxt    = sx_r;
    sy_nxt    = sy_r;
    idx_nxt   = idx_r;
    sumsq_nxt = sumsq_r;
    rem_nxt   = rem_r;
    bit_nxt   = bit_r;
    root_nxt  = root_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    z_nxt     = z_r;
    it_nxt    = it_r;
    res_nxt   = res_r;
    done      = 1'b0;
    sq        = g_r[idx_r] * g_r[idx_r];
    trial     = root_r + 39'(bit_r);
    mag_full  = 20'((root_r + 39'd1) >> 1);
    mag       = (mag_full > 20'(MAG_MAX)) ? MAG_MAX : mag_full[MAG_W-1:0];
    xs        = {{(CORD_W-46){sx_r[21]}}, sx_r, 24'd0};
    ys        = {{(CORD_W-46){sy_r[21]}}, sy_r, 24'd0};
    shx       = y_r >>> it_r;
    shy       = x_r >>> it_r;
    zr        = (z_r + 21'sd4) >>> 3;
    unique case (state_r)
      G_IDLE: if (start) state_nxt = G_DIFF;
      G_DIFF: begin
        sx_nxt = '0;
        sy_nxt = '0;
        for (int c = 0; c < 3; c++) begin
          g_nxt[2*c]   = 20'(cv[1][c]) + 20'(cv[3][c]) - 20'(cv[0][c]) - 20'(cv[2][c]);
          g_nxt[2*c+1] = 20'(cv[0][c]) + 20'(cv[1][c]) - 20'(cv[2][c]) - 20'(cv[3][c]);
          sx_nxt = sx_nxt + 22'(g_nxt[2*c]);
          sy_nxt = sy_nxt + 22'(g_nxt[2*c+1]);
        end
        idx_nxt   = '0;
        sumsq_nxt = '0;
        state_nxt = G_SQ;
      end
      G_SQ: begin
        sumsq_nxt = sumsq_r + sq[37:0];
        if (idx_r == 3'd5) begin
          rem_nxt   = sumsq_r + sq[37:0];
          root_nxt  = '0;
          bit_nxt   = 38'd1 << 36;
          state_nxt = G_SQRT;
        end else begin
          idx_nxt = idx_r + 3'd1;
        end
      end
      G_SQRT: begin
        if (39'(rem_r) >= trial) begin
          rem_nxt  = 38'(39'(rem_r) - trial);
          root_nxt = (root_r >> 1) + 39'(bit_r);
        end else begin
          root_nxt = root_r >> 1;
        end
        bit_nxt = bit_r >> 2;
        if (bit_r == 38'd1) state_nxt = G_MAG;
      end
      G_MAG: begin
        res_nxt.magnitude   = mag;
        res_nxt.undef       = mag < threshold;
        res_nxt.orientation = '0;
        it_nxt = '0;
        if (mag < threshold || (sx_r == '0 && sy_r == '0)) begin
          done = 1'b1;
          state_nxt = G_IDLE;
        end else begin
          if (sx_r < 0) begin
            z_nxt = (sy_r >= 0) ? PI_Q16 : -PI_Q16;
            x_nxt = -xs;
            y_nxt = -ys;
          end else begin
            z_nxt = '0;
            x_nxt = xs;
            y_nxt = ys;
          end
          state_nxt = G_CORD;
        end
      end
      G_CORD: begin
        if (y_r >= 0) begin
          x_nxt = x_r + shx;
          y_nxt = y_r - shy;
          z_nxt = z_r + atan_q16(it_r);
        end else begin
          x_nxt = x_r - shx;
          y_nxt = y_r + shy;
          z_nxt = z_r - atan_q16(it_r);
        end
        it_nxt = it_r + 4'd1;
        if (it_r == 4'd15) state_nxt = G_FIN;
      end
      G_FIN: begin
        if (zr > PI_Q13) res_nxt.orientation = ORIENT_W'(PI_Q13);
        else if (zr < -PI_Q13) res_nxt.orientation = ORIENT_W'(-PI_Q13);
        else res_nxt.orientation = zr[ORIENT_W-1:0];
        done = 1'b1;
        state_nxt = G_IDLE;
      end
      default: state_nxt = G_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= G_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    g_r     <= g_nxt;
    sx_r    <= sx_nxt;
    sy_r    <= sy_nxt;
    idx_r   <= idx_nxt;
    sumsq_r <= sumsq_nxt;
    rem_r   <= rem_nxt;
    bit_r   <= bit_nxt;
    root_r  <= root_nxt;
    x_r     <= x_nxt;
    y_r     <= y_nxt;
    z_r     <= z_nxt;
    it_r    <= it_nxt;
    res_r   <= res_nxt;
  end

  assign result = res_r;

endmodule

FILE: rtl/core/color_gradient_map.sv
// color gradient map top level: frame counters, register file and request handshake
// a request with a result runs 4 corners x (25 tap reads + 6 steps), then 6 squares, 19 root
// and 16 cordic steps plus control, skipping cordic below threshold or for zero sums
// requests are taken one at a time; one with a result holds the input until its result is
// registered for output, which waits while the previous result is not taken; others do not
// sync active-low reset restores counters, registers and output valid; no line store reset
module color_gradient_map import cgm_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_data,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SMOOTH = 4'b0010,
    ST_GRAD   = 4'b0100,
    ST_WAIT   = 4'b1000
  } top_state_t;

  top_state_t state_r, state_nxt;
  logic [WIDTH_W-1:0] image_width_r, image_width_nxt;
  weights_t weights_r, weights_nxt;
  logic [MAG_W-1:0] thresh_r, thresh_nxt;
  logic [WIDTH_W-1:0] frame_width_r, frame_width_nxt;
  logic [COL_W-1:0] col_r, col_nxt, out_col_r, out_col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt, out_row_r, out_row_nxt;
  logic [MAG_W-1:0] max_r, max_nxt;
  logic draining_r, draining_nxt;
  job_t job_r, job_nxt;
  logic last_r, last_nxt, clr_r, clr_nxt;
  logic out_valid_r, out_valid_nxt;
  out_item_t out_data_r, out_data_nxt;

  logic accept, pix_ok, emit, mem_we, smooth_done, grad_done;
  logic [WIDTH_W-1:0] fw_cur, col_inc, oc_inc;
  logic [ADDR_W-1:0] rd_addr;
  logic [PIX_W-1:0] rd_data;
  ycc_t [3:0] corners;
  grad_res_t gres;
  logic [MAG_W-1:0] mag_max;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    image_width_nxt = image_width_r;
    weights_nxt     = weights_r;
    thresh_nxt      = thresh_r;
    if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_IMAGE_WIDTH: image_width_nxt = cfg_data[WIDTH_W-1:0];
        CFG_WEIGHT_D0:   weights_nxt.w0 = cfg_data[15:0];
        CFG_WEIGHT_D1:   weights_nxt.w1 = cfg_data[15:0];
        CFG_WEIGHT_D2:   weights_nxt.w2 = cfg_data[15:0];
        CFG_WEIGHT_D4:   weights_nxt.w4 = cfg_data[15:0];
        CFG_WEIGHT_D5:   weights_nxt.w5 = cfg_data[15:0];
        CFG_WEIGHT_D8:   weights_nxt.w8 = cfg_data[15:0];
        CFG_MAG_THRESH:  thresh_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt       = state_r;
    frame_width_nxt = frame_width_r;
    col_nxt         = col_r;
    row_nxt         = row_r;
    out_col_nxt     = out_col_r;
    out_row_nxt     = out_row_r;
    max_nxt         = max_r;
    draining_nxt    = draining_r;
    job_nxt         = job_r;
    last_nxt        = last_r;
    clr_nxt         = clr_r;
    out_valid_nxt   = out_valid_r;
    out_data_nxt    = out_data_r;
    emit            = 1'b0;
    mem_we          = 1'b0;
    mag_max         = (gres.magnitude > max_r) ? gres.magnitude : max_r;

    fw_cur  = (row_r == '0 && col_r == '0) ? clamp_width(image_width_r) : frame_width_r;
    pix_ok  = !draining_r && (row_r < ROW_W'(MAX_HEIGHT));
    col_inc = {1'b0, col_r} + WIDTH_W'(1);
    oc_inc  = {1'b0, out_col_r} + WIDTH_W'(1);

    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;

    if (accept) begin
      if (!in_data.command) begin
        if (pix_ok) begin
          mem_we          = 1'b1;
          frame_width_nxt = fw_cur;
          if (col_inc >= fw_cur) begin
            col_nxt = '0;
            row_nxt = row_r + ROW_W'(1);
          end else begin
            col_nxt = col_inc[COL_W-1:0];
          end
          if (row_r >= ROW_W'(4)) begin
            emit       = 1'b1;
            job_nxt.oi = out_row_r;
            job_nxt.oj = out_col_r;
            job_nxt.bottom = row_nxt - ROW_W'(1);
            job_nxt.width  = fw_cur;
            last_nxt   = 1'b0;
            clr_nxt    = 1'b0;
            if (oc_inc >= fw_cur) begin
              out_col_nxt = '0;
              out_row_nxt = out_row_r + ROW_W'(1);
            end else begin
              out_col_nxt = oc_inc[COL_W-1:0];
            end
          end
        end
      end else begin
        draining_nxt = 1'b1;
        if (out_row_r >= row_r) begin
          col_nxt      = '0;
          row_nxt      = '0;
          out_col_nxt  = '0;
          out_row_nxt  = '0;
          max_nxt      = '0;
          draining_nxt = 1'b0;
        end else begin
          emit           = 1'b1;
          job_nxt.oi     = out_row_r;
          job_nxt.oj     = out_col_r;
          job_nxt.bottom = row_r - ROW_W'(1);
          job_nxt.width  = frame_width_r;
          last_nxt = (out_row_r == row_r - ROW_W'(1)) && (oc_inc == frame_width_r);
          clr_nxt  = last_nxt;
          if (oc_inc >= frame_width_r) begin
            out_col_nxt = '0;
            out_row_nxt = out_row_r + ROW_W'(1);
          end else begin
            out_col_nxt = oc_inc[COL_W-1:0];
          end
          if (last_nxt) begin
            col_nxt      = '0;
            row_nxt      = '0;
            out_col_nxt  = '0;
            out_row_nxt  = '0;
            draining_nxt = 1'b0;
          end
        end
      end
      if (emit) state_nxt = ST_SMOOTH;
    end

    unique case (state_r)
      ST_IDLE: ;
      ST_SMOOTH: if (smooth_done) state_nxt = ST_GRAD;
      ST_GRAD: if (grad_done) state_nxt = ST_WAIT;
      ST_WAIT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt.magnitude             = gres.magnitude;
          out_data_nxt.orientation           = gres.orientation;
          out_data_nxt.orientation_undefined = gres.undef;
          out_data_nxt.frame_max             = mag_max;
          out_data_nxt.last                  = last_r;
          max_nxt   = clr_r ? '0 : mag_max;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      image_width_r <= WIDTH_W'(MAX_WIDTH);
      weights_r     <= '{w0: 16'd11692, w1: 16'd6718, w2: 16'd3861,
                         w4: 16'd1275, w5: 16'd733, w8: 16'd139};
      thresh_r      <= 18'd1338;
      frame_width_r <= WIDTH_W'(MAX_WIDTH);
      col_r         <= '0;
      row_r         <= '0;
      out_col_r     <= '0;
      out_row_r     <= '0;
      max_r         <= '0;
      draining_r    <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      image_width_r <= image_width_nxt;
      weights_r     <= weights_nxt;
      thresh_r      <= thresh_nxt;
      frame_width_r <= frame_width_nxt;
      col_r         <= col_nxt;
      row_r         <= row_nxt;
      out_col_r     <= out_col_nxt;
      out_row_r     <= out_row_nxt;
      max_r         <= max_nxt;
      draining_r    <= draining_nxt;
      out_valid_r   <= out_valid_nxt;
    end
    job_r      <= job_nxt;
    last_r     <= last_nxt;
    clr_r      <= clr_nxt;
    out_data_r <= out_data_nxt;
  end

  cgm_line_store u_store (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr ({row_r[ROWSEL_W-1:0], col_r}),
    .wr_data ({in_data.red, in_data.green, in_data.blue}),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  cgm_smooth u_smooth (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (state_r == ST_SMOOTH),
    .job     (job_r),
    .weights (weights_r),
    .rd_data (rd_data),
    .rd_addr (rd_addr),
    .done    (smooth_done),
    .corners (corners)
  );

  cgm_grad u_grad (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (smooth_done),
    .corners   (corners),
    .threshold (thresh_r),
    .done      (grad_done),
    .result    (gres)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    smooth_done |-> state_r == ST_SMOOTH)
    else $error("smoothing finished outside its phase");

  assert property (@(posedge clk) disable iff (!rst_n)
    grad_done |-> state_r == ST_GRAD)
    else $error("gradient finished outside its phase");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_data_r.frame_max >= out_data_r.magnitude)
    else $error("frame maximum below result magnitude");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.orientation_undefined |-> out_data_r.orientation == '0)
    else $error("undefined orientation not zero");

  assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, col_r} < frame_width_r)
    else $error("column counter beyond frame width");

endmodule

FILE: dv/cgm_checker.sv
// color gradient map checker: watches requests and results, predicts and compares
`timescale 1ns / 100ps

module cgm_checker import cgm_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_ready,
  input  in_item_t         in_data,
  input  logic             out_valid,
  input  logic             out_ready,
  input  out_item_t        out_data,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  output int               errors,
  output int               pending
);

  localparam logic CMD_FLUSH = 1'b1;

  logic [PIX_W-1:0] pixel_rows [ROWS_KEPT*MAX_WIDTH];
  out_item_t        expected_q[$];

  int unsigned col_cnt, row_cnt, res_cnt, peak_mag, frame_w, img_w, mag_thresh;
  logic [15:0] tap_w [6];
  bit draining;

  function automatic longint unsigned weight_at(int d);
    case (d)
      0: return tap_w[0];
      1: return tap_w[1];
      2: return tap_w[2];
      4: return tap_w[3];
      5: return tap_w[4];
      default: return tap_w[5];
    endcase
  endfunction

  function automatic int unsigned limit_width(int unsigned w);
    if (w == 0) return 1;
    return (w > MAX_WIDTH) ? MAX_WIDTH : w;
  endfunction

  function automatic int clip(int v, int lo, int hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // smoothed luma/chroma in q8.8 at (i,j)
  function automatic void smooth_ycc(input int i, input int j, input int bottom, input int w,
                                     output longint yv, output longint cb, output longint cr);
    longint unsigned acc [3];
    longint unsigned s [3];
    logic [PIX_W-1:0] p;
    int r, c;
    longint unsigned wt;
    acc = '{0, 0, 0};
    for (int dy = -2; dy <= 2; dy++) begin
      for (int dx = -2; dx <= 2; dx++) begin
        r = clip(i + dy, 0, bottom);
        c = clip(j + dx, 0, w - 1);
        p = pixel_rows[(r % ROWS_KEPT) * MAX_WIDTH + c];
        wt = weight_at(dy * dy + dx * dx);
        acc[0] += wt * p[23:16];
        acc[1] += wt * p[15:8];
        acc[2] += wt * p[7:0];
      end
    end
    for (int k = 0; k < 3; k++) begin
      s[k] = (acc[k] + 128) >> 8;
      if (s[k] > SMOOTH_MAX) s[k] = SMOOTH_MAX;
    end
    yv = longint'((Y_COEF_R * s[0] + Y_COEF_G * s[1] + Y_COEF_B * s[2] + 32768) >> 16);
    cb = ((longint'(s[2]) - yv) * longint'(CB_COEF) + 32768) >>> 16;
    cr = ((longint'(s[0]) - yv) * longint'(CR_COEF) + 32768) >>> 16;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint angle_of(longint y, longint x);
    longint z, r, sx, sy;
    z = 0;
    if (x == 0 && y == 0) return 0;
    x = x * 16777216;
    y = y * 16777216;
    if (x < 0) begin
      z = (y >= 0) ? longint'(PI_Q16) : -longint'(PI_Q16);
      x = -x;
      y = -y;
    end
    for (int i = 0; i < 16; i++) begin
      sx = y >>> i;
      sy = x >>> i;
      if (y >= 0) begin
        x += sx; y -= sy; z += longint'(atan_q16(4'(i)));
      end else begin
        x -= sx; y += sy; z -= longint'(atan_q16(4'(i)));
      end
    end
    r = (z + 4) >>> 3;
    if (r > PI_Q13) r = PI_Q13;
    if (r < -longint'(PI_Q13)) r = -longint'(PI_Q13);
    return r;
  endfunction

  function automatic out_item_t gradient_at(int unsigned k, bit last);
    out_item_t res;
    int w, bottom, oi, oj, jr, ib;
    longint a [3], b [3], c [3], d [3];
    longint gx, gy, sx, sy;
    longint unsigned sumsq, mag;
    bit undef;
    w = frame_w;
    bottom = row_cnt - 1;
    oi = k / frame_w;
    oj = k % frame_w;
    jr = clip(oj + 1, 0, w - 1);
    ib = clip(oi + 1, 0, bottom);
    smooth_ycc(oi, oj, bottom, w, a[0], a[1], a[2]);
    smooth_ycc(oi, jr, bottom, w, b[0], b[1], b[2]);
    smooth_ycc(ib, oj, bottom, w, c[0], c[1], c[2]);
    smooth_ycc(ib, jr, bottom, w, d[0], d[1], d[2]);
    sumsq = 0; sx = 0; sy = 0;
    for (int ch = 0; ch < 3; ch++) begin
      gx = b[ch] + d[ch] - a[ch] - c[ch];
      gy = a[ch] + b[ch] - c[ch] - d[ch];
      sumsq += longint'(gx * gx) + longint'(gy * gy);
      sx += gx;
      sy += gy;
    end
    mag = (int_sqrt(sumsq) + 1) >> 1;
    if (mag > MAG_MAX) mag = MAG_MAX;
    undef = mag < mag_thresh;
    if (mag > peak_mag) peak_mag = mag;
    res.magnitude = MAG_W'(mag);
    res.orientation = undef ? '0 : ORIENT_W'(angle_of(sy, sx));
    res.orientation_undefined = undef;
    res.frame_max = MAG_W'(peak_mag);
    res.last = last;
    return res;
  endfunction

  function automatic void close_frame();
    col_cnt = 0; row_cnt = 0; res_cnt = 0; peak_mag = 0; draining = 0;
  endfunction

  function automatic void add_expected(out_item_t r);
    expected_q = {expected_q, r};
  endfunction

  function automatic void take_request(in_item_t it);
    int unsigned n, total;
    bit last;
    if (it.command != CMD_FLUSH) begin
      if (draining || row_cnt >= MAX_HEIGHT) return;
      if (row_cnt == 0 && col_cnt == 0) frame_w = limit_width(img_w);
      pixel_rows[(row_cnt % ROWS_KEPT) * MAX_WIDTH + col_cnt] = {it.red, it.green, it.blue};
      n = row_cnt * frame_w + col_cnt;
      col_cnt++;
      if (col_cnt >= frame_w) begin
        col_cnt = 0;
        row_cnt++;
      end
      if (n >= 4 * frame_w) begin
        add_expected(gradient_at(res_cnt, 0));
        res_cnt++;
      end
    end else begin
      draining = 1;
      total = row_cnt * frame_w;
      if (res_cnt >= total) begin
        close_frame();
        return;
      end
      last = (res_cnt + 1 == total);
      add_expected(gradient_at(res_cnt, last));
      res_cnt++;
      if (last) close_frame();
    end
  endfunction

  task automatic mismatch(string field, longint e, longint a);
    $display("%t: %s mismatch, expected %0d, got %0d", $time, field, e, a);
    errors++;
  endtask

  task automatic check_result(out_item_t got);
    out_item_t e;
    if (expected_q.size() == 0) begin
      $display("%t: unexpected result %p", $time, got);
      errors++;
      return;
    end
    e = expected_q.pop_front();
    if (got.magnitude != e.magnitude) mismatch("magnitude", e.magnitude, got.magnitude);
    if (got.orientation != e.orientation)
      mismatch("orientation", e.orientation, got.orientation);
    if (got.orientation_undefined != e.orientation_undefined)
      mismatch("orientation_undefined", e.orientation_undefined, got.orientation_undefined);
    if (got.frame_max != e.frame_max) mismatch("frame_max", e.frame_max, got.frame_max);
    if (got.last != e.last) mismatch("last", e.last, got.last);
  endtask

  initial begin
    errors = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      img_w = MAX_WIDTH;
      tap_w = '{16'd11692, 16'd6718, 16'd3861, 16'd1275, 16'd733, 16'd139};
      mag_thresh = 1338;
      frame_w = limit_width(img_w);
      close_frame();
      expected_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index_t'(cfg_index))
          CFG_IMAGE_WIDTH: img_w = cfg_data[10:0];
          CFG_WEIGHT_D0:   tap_w[0] = cfg_data[15:0];
          CFG_WEIGHT_D1:   tap_w[1] = cfg_data[15:0];
          CFG_WEIGHT_D2:   tap_w[2] = cfg_data[15:0];
          CFG_WEIGHT_D4:   tap_w[3] = cfg_data[15:0];
          CFG_WEIGHT_D5:   tap_w[4] = cfg_data[15:0];
          CFG_WEIGHT_D8:   tap_w[5] = cfg_data[15:0];
          CFG_MAG_THRESH:  mag_thresh = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready) check_result(out_data);
      if (in_valid && in_ready) take_request(in_data);
    end
    pending <= expected_q.size();
  end

  final if (expected_q.size() != 0) $display("%t: %0d results never arrived", $time,
                                             expected_q.size());

endmodule

FILE: dv/tb_color_gradient_map.sv
// color gradient map testbench top: clock, reset, stimulus and verdict
`timescale 1ns / 100ps

module tb_color_gradient_map;
  import cgm_pkg::*;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;
  localparam int   DRAIN_CYCLES = 200;

  logic             clk;
  logic             rst_n;
  logic             in_valid, in_ready, out_valid, out_ready;
  in_item_t         in_data;
  out_item_t        out_data;
  logic             cfg_we;
  logic [2:0]       cfg_index;
  logic [CFG_W-1:0] cfg_data;
  int               errors, pending;

  bit quiet, long_hold;
  int n_items, hold_cnt, cur_w, cur_thr;
  int cur_wt [6];

  color_gradient_map i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  cgm_checker i_chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .pending(pending)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result side back-pressure
  always @(posedge clk) begin
    if (long_hold) begin
      long_hold <= 1'b0;
      hold_cnt = 3000;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      hold_cnt = $urandom_range(0, 12);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic send(in_item_t it);
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    n_items++;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_regs();
    cfg_we <= 1'b1;
    cfg_index <= CFG_IMAGE_WIDTH;
    cfg_data <= CFG_W'(cur_w);
    @(posedge clk);
    for (int k = 0; k < 6; k++) begin
      cfg_index <= 3'(int'(CFG_WEIGHT_D0) + k);
      cfg_data <= CFG_W'(cur_wt[k]);
      @(posedge clk);
    end
    cfg_index <= CFG_MAG_THRESH;
    cfg_data <= CFG_W'(cur_thr);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic in_item_t make_pixel(int mode, int k);
    in_item_t it;
    it.command = CMD_PIXEL;
    case (mode)
      1: {it.red, it.green, it.blue} = {8'd77, 8'd77, 8'd77};
      2: {it.red, it.green, it.blue} = {{8{$urandom_range(0, 1) == 1}},
                                        {8{$urandom_range(0, 1) == 1}},
                                        {8{$urandom_range(0, 1) == 1}}};
      3: {it.red, it.green, it.blue} = {8'(k * 9), 8'(255 - k * 5), 8'(k * k)};
      default: {it.red, it.green, it.blue} = 24'($urandom);
    endcase
    return it;
  endfunction

  function automatic in_item_t flush_req();
    in_item_t it;
    it = in_item_t'($urandom);
    it.command = CMD_FLUSH;
    return it;
  endfunction

  // enough flushes to drain the frame after its pixels, with an optional stray pixel; lw is the latched width
  task automatic drain_frame(int lw, int npix, bit stray_pixel);
    int rows, emitted, left;
    if (npix > MAX_HEIGHT * lw) npix = MAX_HEIGHT * lw;
    rows = npix / lw;
    emitted = (npix > 4 * lw) ? npix - 4 * lw : 0;
    left = rows * lw - emitted;
    if (left < 0) left = 0;
    send(flush_req());
    if (stray_pixel && left >= 2) send(make_pixel(0, 0));
    for (int k = 1; k <= left; k++) send(flush_req());
  endtask

  function automatic int latched(int w);
    if (w == 0) return 1;
    return (w > MAX_WIDTH) ? MAX_WIDTH : w;
  endfunction

  task automatic frame(int npix, int mode, bit stray_pixel);
    for (int k = 0; k < npix; k++) send(make_pixel(mode, k));
    drain_frame(latched(cur_w), npix, stray_pixel);
    wait_idle();
  endtask

  initial begin
    int w, rows, npix;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    out_ready <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= CFG_IMAGE_WIDTH;
    cfg_data <= '0;
    quiet = 0;
    long_hold = 0;
    hold_cnt = 0;
    n_items = 0;
    cur_w = MAX_WIDTH;
    cur_wt = '{11692, 6718, 3861, 1275, 733, 139};
    cur_thr = 1338;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // flush with nothing pending
    send(flush_req());
    wait_idle();
    cur_w = 3;
    write_regs();
    frame(16, 3, 1);
    // width zero acts as one
    cur_w = 0;
    write_regs();
    frame(7, 2, 0);
    // width change inside a frame keeps the latched width
    cur_w = 4;
    write_regs();
    for (int k = 0; k < 6; k++) send(make_pixel(0, k));
    wait_idle();
    cur_w = 7;
    write_regs();
    for (int k = 0; k < 17; k++) send(make_pixel(2, k));
    drain_frame(4, 23, 0);
    wait_idle();
    // saturated and zero weights, extreme thresholds, flat frames
    cur_w = 5;
    cur_wt = '{65535, 65535, 65535, 65535, 65535, 65535};
    cur_thr = 262143;
    write_regs();
    frame(25, 2, 0);
    cur_wt = '{0, 0, 0, 0, 0, 0};
    cur_thr = 0;
    write_regs();
    frame(10, 0, 0);
    cur_wt = '{11692, 6718, 3861, 1275, 733, 139};
    write_regs();
    frame(15, 1, 0);
    // width above the maximum, one full row plus a partial one
    cur_w = 2047;
    cur_thr = 1338;
    write_regs();
    frame(MAX_WIDTH + 3, 0, 0);
    // rows beyond the maximum height are ignored
    cur_w = 1;
    write_regs();
    frame(MAX_HEIGHT + 4, 0, 0);

    n_items = 0;
    cur_w = 6;
    write_regs();
    long_hold = 1;
    frame(40, 0, 0);
    while (n_items < 2000) begin
      if (n_items > 1700) quiet = 1;
      if ($urandom_range(0, 4) == 0) begin
        for (int k = 0; k < 6; k++)
          cur_wt[k] = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                  : $urandom_range(0, 12000);
        cur_thr = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 262143)
                                              : $urandom_range(0, 3000);
      end
      w = ($urandom_range(0, 4) != 0) ? $urandom_range(1, 8) : $urandom_range(9, 40);
      rows = $urandom_range(1, 9);
      npix = rows * w;
      if ($urandom_range(0, 3) == 0) npix += $urandom_range(0, w);
      if ($urandom_range(0, 9) == 0) npix = $urandom_range(0, 3 * w);
      cur_w = w;
      write_regs();
      frame(npix, ($urandom_range(0, 5) == 0) ? 2 : 0, $urandom_range(0, 4) == 0);
    end

    wait_idle();
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #80_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
